// File: hdl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants of the load driven frequency stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

  localparam int FREQ_BITS_DEF = 22;
  localparam int PCT_W         = 7;
  localparam int BOOST_W       = 3;
  localparam int INDEX_W       = 3;

  localparam logic [PCT_W-1:0]   RISE_LOAD_RST       = 7'd80;
  localparam logic [PCT_W-1:0]   FALL_LOAD_RST       = 7'd20;
  localparam logic [PCT_W-1:0]   STEP_PERCENT_RST    = 7'd5;
  localparam logic               BOOST_ENABLE_RST    = 1'b1;
  localparam logic [BOOST_W-1:0] BOOST_THRESHOLD_RST = 3'd3;
  localparam logic [31:0]        MAX_FREQ_RST        = 32'd2000000;
  localparam logic [31:0]        MIN_FREQ_RST        = 32'd300000;
  localparam logic               GOVERNOR_ON_RST     = 1'b1;

  localparam logic [BOOST_W-1:0] RISE_MAX      = 3'd7;
  localparam int                 FALLBACK_STEP = 5;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_NOTICE = 1'b1;

  localparam logic REL_AT_OR_BELOW = 1'b0;
  localparam logic REL_AT_OR_ABOVE = 1'b1;

  typedef enum logic [INDEX_W-1:0] {
    REG_RISE_LOAD       = 3'd0,
    REG_FALL_LOAD       = 3'd1,
    REG_STEP_PERCENT    = 3'd2,
    REG_BOOST_ENABLE    = 3'd3,
    REG_BOOST_THRESHOLD = 3'd4,
    REG_MAX_FREQ        = 3'd5,
    REG_MIN_FREQ        = 3'd6,
    REG_GOVERNOR_ON     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PCT_W-1:0]   rise_load;
    logic [PCT_W-1:0]   fall_load;
    logic [PCT_W-1:0]   step_percent;
    logic               boost_enable;
    logic [BOOST_W-1:0] boost_threshold;
    logic               governor_on;
  } cfg_ctl_t;

endpackage

`default_nettype wire

// File: hdl/lfs_channels.sv
// ----------------------------------------------------------------------------
// lfs_channels
// Valid/ready channels for load samples and frequency requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lfs_item_if #(
  parameter int FREQ_BITS = lfs_pkg::FREQ_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [lfs_pkg::PCT_W-1:0]  load_percent;
  logic [FREQ_BITS-1:0]       current_freq;
  logic                       suspended;
  logic [FREQ_BITS-1:0]       new_freq;

  modport source (
    output valid, action, load_percent, current_freq, suspended, new_freq,
    input  ready
  );
  modport sink (
    input  valid, action, load_percent, current_freq, suspended, new_freq,
    output ready
  );
endinterface

interface lfs_result_if #(
  parameter int FREQ_BITS = lfs_pkg::FREQ_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FREQ_BITS-1:0] target_freq;
  logic                 relation;

  modport source (output valid, target_freq, relation, input ready);
  modport sink (input valid, target_freq, relation, output ready);
endinterface

`default_nettype wire

// File: hdl/load_driven_frequency_stepper_unit.sv
// ----------------------------------------------------------------------------
// load_driven_frequency_stepper_unit
// Tracks a requested CPU frequency and steps it up or down on load samples.
// ----------------------------------------------------------------------------
// Usage: items arrive on the item channel (load samples or frequency-change
// notices) and frequency requests leave on the result channel; each channel
// moves one transaction per edge with valid and ready both high. Registers
// are written through cfg_write / cfg_index / cfg_data; the user must write
// them only while no item is in flight, as the block does not enforce it.
// The configuration seen at acceptance travels with the item. The step size
// (step_percent * max_freq / 100, or 5 where that is zero) is formed in a
// four stage multiply-by-reciprocal pipeline, after which a single stage
// updates the requested frequency and the rise counter. Items pass through
// s0 to s4 into the result register; one item per cycle is sustained without stalls.
// Items that give no request leave no trace on the result channel.
// When the receiver stalls, the result register holds; items behind it keep
// moving into empty stages, and the item channel drops ready once the stage
// holding a request that cannot be delivered blocks the pipeline.
// Reset (rst, synchronous) restores register defaults, clears the requested
// frequency and the rise counter and empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module load_driven_frequency_stepper_unit #(
  parameter int FREQ_BITS = lfs_pkg::FREQ_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [lfs_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [FREQ_BITS-1:0]        cfg_data,
  lfs_item_if.sink                         item,
  lfs_result_if.source                     result
);

  localparam int QW   = FREQ_BITS - 6;
  localparam int SW   = FREQ_BITS + 1;
  localparam int MW   = FREQ_BITS - 1;
  localparam int NSH  = FREQ_BITS + 3;
  localparam int PW   = 2 * FREQ_BITS - 3;
  localparam int PCTW = lfs_pkg::PCT_W;
  localparam logic [63:0]   MAG64 = ((64'd1 << NSH) + 64'd24) / 64'd25;
  localparam logic [MW-1:0] MAG   = MAG64[MW-1:0];
  localparam logic [12:0]   MAG_SMALL = 13'd5243;

  typedef struct packed {
    logic                  action;
    logic [PCTW-1:0]       load_percent;
    logic [FREQ_BITS-1:0]  current_freq;
    logic                  suspended;
    logic [FREQ_BITS-1:0]  new_freq;
    lfs_pkg::cfg_ctl_t     ctl;
    logic [FREQ_BITS-1:0]  max_freq;
    logic [FREQ_BITS-1:0]  min_freq;
  } item_t;

  lfs_pkg::cfg_ctl_t    cfg_ctl;
  logic [FREQ_BITS-1:0] cfg_max;
  logic [FREQ_BITS-1:0] cfg_min;

  lfs_cfg_regs #(.FREQ_BITS(FREQ_BITS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ctl      (cfg_ctl),
    .max_freq (cfg_max),
    .min_freq (cfg_min)
  );

  item_t             s0, s1, s2, s3, s4;
  logic [4:0]        v;
  logic [4:0]        free;
  logic [QW-1:0]     s1_q;
  logic [PCTW-1:0]   s2_r;
  logic [SW-1:0]     s2_pq;
  logic [SW-1:0]     s3_pq;
  logic [13:0]       s3_pr;
  logic [SW-1:0]     s4_step;

  logic [FREQ_BITS-1:0] tracked_freq, tracked_freq_next;
  logic [lfs_pkg::BOOST_W-1:0] rise_count, rise_count_next;

  logic                 out_valid;
  logic [FREQ_BITS-1:0] out_target;
  logic                 out_relation;

  logic                 res_fire;
  logic [FREQ_BITS-1:0] res_target;
  logic                 res_relation;
  logic                 can4;

  logic [PW-1:0]        prod_q;
  logic [PCTW-1:0]      q100_lo;
  logic [24:0]          prod_small;
  logic [SW-1:0]        step_sum;
  logic [FREQ_BITS+1:0] rise_sum;

  item_t in_item;

  assign in_item.action       = item.action;
  assign in_item.load_percent = item.load_percent;
  assign in_item.current_freq = item.current_freq;
  assign in_item.suspended    = item.suspended;
  assign in_item.new_freq     = item.new_freq;
  assign in_item.ctl          = cfg_ctl;
  assign in_item.max_freq     = cfg_max;
  assign in_item.min_freq     = cfg_min;

  // pipeline flow
  assign can4    = !res_fire || !out_valid || result.ready;
  assign free[4] = !v[4] || can4;
  assign free[3] = !v[3] || free[4];
  assign free[2] = !v[2] || free[3];
  assign free[1] = !v[1] || free[2];
  assign free[0] = !v[0] || free[1];
  assign item.ready = free[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[0]) v[0] <= item.valid;
      if (free[1]) v[1] <= v[0];
      if (free[2]) v[2] <= v[1];
      if (free[3]) v[3] <= v[2];
      if (free[4]) v[4] <= v[3];
    end
  end

  // step size datapath
  always_comb begin
    prod_q     = PW'(s0.max_freq[FREQ_BITS-1:2]) * PW'(MAG);
    q100_lo    = PCTW'({s1_q[0], 6'b0}) + PCTW'({s1_q[1:0], 5'b0})
               + PCTW'({s1_q[4:0], 2'b0});
    prod_small = 25'(s3_pr[13:2]) * 25'(MAG_SMALL);
    step_sum   = s3_pq + SW'(prod_small[24:17]);
  end

  always_ff @(posedge clk) begin
    if (free[0]) s0 <= in_item;
    if (free[1]) begin
      s1   <= s0;
      s1_q <= prod_q[PW-1:NSH];
    end
    if (free[2]) begin
      s2    <= s1;
      s2_r  <= s1.max_freq[PCTW-1:0] - q100_lo;
      s2_pq <= SW'(s1.ctl.step_percent) * SW'(s1_q);
    end
    if (free[3]) begin
      s3    <= s2;
      s3_pq <= s2_pq;
      s3_pr <= 14'(s2.ctl.step_percent) * 14'(s2_r);
    end
    if (free[4]) begin
      s4      <= s3;
      s4_step <= (step_sum == '0) ? SW'(lfs_pkg::FALLBACK_STEP) : step_sum;
    end
  end

  // frequency update
  always_comb begin
    tracked_freq_next = tracked_freq;
    rise_count_next   = rise_count;
    res_fire          = 1'b0;
    res_target        = tracked_freq;
    res_relation      = lfs_pkg::REL_AT_OR_BELOW;
    rise_sum          = (FREQ_BITS+2)'(tracked_freq) + (FREQ_BITS+2)'(s4_step);
    if (s4.ctl.boost_enable && rise_count >= s4.ctl.boost_threshold) begin
      rise_sum = (FREQ_BITS+2)'(s4.max_freq);
    end
    priority if (s4.action == lfs_pkg::ACTION_NOTICE) begin
      if (s4.ctl.governor_on &&
          (tracked_freq > s4.max_freq || tracked_freq < s4.min_freq)) begin
        tracked_freq_next = s4.new_freq;
      end
    end else if (s4.ctl.step_percent == '0) begin
      tracked_freq_next = tracked_freq;
    end else if (s4.load_percent > s4.ctl.rise_load) begin
      if (tracked_freq != s4.max_freq && !s4.suspended) begin
        if (rise_sum >= (FREQ_BITS+2)'(s4.max_freq)) begin
          tracked_freq_next = s4.max_freq;
        end else begin
          tracked_freq_next = rise_sum[FREQ_BITS-1:0];
          if (rise_count != lfs_pkg::RISE_MAX) begin
            rise_count_next = rise_count + lfs_pkg::BOOST_W'(1);
          end
        end
        res_fire     = 1'b1;
        res_target   = tracked_freq_next;
        res_relation = lfs_pkg::REL_AT_OR_BELOW;
      end
    end else if (s4.load_percent < s4.ctl.fall_load) begin
      if (s4.current_freq != s4.min_freq) begin
        if (SW'(tracked_freq) > s4_step) begin
          tracked_freq_next = tracked_freq - s4_step[FREQ_BITS-1:0];
        end else begin
          tracked_freq_next = s4.min_freq;
        end
        res_fire     = 1'b1;
        res_target   = tracked_freq_next;
        res_relation = lfs_pkg::REL_AT_OR_ABOVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_freq <= '0;
      rise_count   <= '0;
    end else if (v[4] && can4) begin
      tracked_freq <= tracked_freq_next;
      rise_count   <= rise_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (v[4] && can4 && res_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v[4] && can4 && res_fire) begin
      out_target   <= res_target;
      out_relation <= res_relation;
    end
  end

  assign result.valid       = out_valid;
  assign result.target_freq = out_target;
  assign result.relation    = out_relation;

endmodule

`default_nettype wire

// File: hdl/lfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfs_cfg_regs
// Configuration register file of the frequency stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfs_cfg_regs #(
  parameter int FREQ_BITS = lfs_pkg::FREQ_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lfs_pkg::INDEX_W-1:0]   cfg_index,
  input  wire logic [FREQ_BITS-1:0]          cfg_data,
  output lfs_pkg::cfg_ctl_t                  ctl,
  output logic      [FREQ_BITS-1:0]          max_freq,
  output logic      [FREQ_BITS-1:0]          min_freq
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.rise_load       <= lfs_pkg::RISE_LOAD_RST;
      ctl.fall_load       <= lfs_pkg::FALL_LOAD_RST;
      ctl.step_percent    <= lfs_pkg::STEP_PERCENT_RST;
      ctl.boost_enable    <= lfs_pkg::BOOST_ENABLE_RST;
      ctl.boost_threshold <= lfs_pkg::BOOST_THRESHOLD_RST;
      ctl.governor_on     <= lfs_pkg::GOVERNOR_ON_RST;
      max_freq            <= lfs_pkg::MAX_FREQ_RST[FREQ_BITS-1:0];
      min_freq            <= lfs_pkg::MIN_FREQ_RST[FREQ_BITS-1:0];
    end else if (cfg_write) begin
      unique case (lfs_pkg::cfg_reg_t'(cfg_index))
        lfs_pkg::REG_RISE_LOAD:       ctl.rise_load       <= cfg_data[lfs_pkg::PCT_W-1:0];
        lfs_pkg::REG_FALL_LOAD:       ctl.fall_load       <= cfg_data[lfs_pkg::PCT_W-1:0];
        lfs_pkg::REG_STEP_PERCENT:    ctl.step_percent    <= cfg_data[lfs_pkg::PCT_W-1:0];
        lfs_pkg::REG_BOOST_ENABLE:    ctl.boost_enable    <= cfg_data[0];
        lfs_pkg::REG_BOOST_THRESHOLD: ctl.boost_threshold <= cfg_data[lfs_pkg::BOOST_W-1:0];
        lfs_pkg::REG_MAX_FREQ:        max_freq            <= cfg_data;
        lfs_pkg::REG_MIN_FREQ:        min_freq            <= cfg_data;
        lfs_pkg::REG_GOVERNOR_ON:     ctl.governor_on     <= cfg_data[0];
      endcase
    end
  end

endmodule

`default_nettype wire

// File: test/load_driven_frequency_stepper_unit_test.sv
// ----------------------------------------------------------------------------
// load_driven_frequency_stepper_unit_test
// Drives load samples and frequency-change notices into the stepper with
// random gaps and result stalls, tracks the requested frequency and the rise
// count alongside the block, and checks every frequency request in order.
// Register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module load_driven_frequency_stepper_unit_test;

  import lfs_pkg::*;

  localparam int FB          = FREQ_BITS_DEF;
  localparam int FREQ_TOP    = (1 << FB) - 1;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic             action;
    logic [PCT_W-1:0] load_percent;
    logic [FB-1:0]    current_freq;
    logic             suspended;
    logic [FB-1:0]    new_freq;
  } sample_t;

  typedef struct packed {
    logic [FB-1:0] target_freq;
    logic          relation;
  } request_t;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [INDEX_W-1:0] cfg_index;
  logic [FB-1:0]    cfg_data;

  lfs_item_if   #(.FREQ_BITS(FB)) item_ch ();
  lfs_result_if #(.FREQ_BITS(FB)) req_ch ();

  load_driven_frequency_stepper_unit #(.FREQ_BITS(FB)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (req_ch)
  );

  // governor state and settings as the block should hold them
  cfg_ctl_t           ctl;
  logic [FB-1:0]      max_khz;
  logic [FB-1:0]      min_khz;
  logic [FB-1:0]      req_khz;
  logic [BOOST_W-1:0] rise_cnt;

  sample_t  queued_samples[$];
  request_t owed_requests[$];
  int       issued_count;
  int       accepted_count;
  int       error_count;
  int       quiet_cycles;
  bit       item_taken;
  bit       result_taken;
  int       send_gap;
  int       send_calm;
  int       recv_gap;
  int       recv_calm;

  always #4 clk = ~clk;

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 12);
  endfunction

  function automatic bit track_request(input sample_t s, output request_t req);
    logic [63:0] stride;
    logic [63:0] nxt;
    track_request = 1'b0;
    req = '0;
    stride = (64'(ctl.step_percent) * 64'(max_khz)) / 64'd100;
    if (stride == 0) stride = 64'(FALLBACK_STEP);
    if (s.action == ACTION_NOTICE) begin
      if (ctl.governor_on && (req_khz > max_khz || req_khz < min_khz)) req_khz = s.new_freq;
    end else if (ctl.step_percent != 0) begin
      if (s.load_percent > ctl.rise_load) begin
        if (req_khz != max_khz && !s.suspended) begin
          if (ctl.boost_enable && rise_cnt >= ctl.boost_threshold) nxt = 64'(max_khz);
          else nxt = 64'(req_khz) + stride;
          if (nxt >= 64'(max_khz)) begin
            nxt = 64'(max_khz);
          end else if (rise_cnt < RISE_MAX) begin
            rise_cnt = rise_cnt + 1'b1;
          end
          req_khz = nxt[FB-1:0];
          req.target_freq = req_khz;
          req.relation = REL_AT_OR_BELOW;
          track_request = 1'b1;
        end
      end else if (s.load_percent < ctl.fall_load && s.current_freq != min_khz) begin
        if (64'(req_khz) > stride) req_khz = req_khz - stride[FB-1:0];
        else req_khz = min_khz;
        req.target_freq = req_khz;
        req.relation = REL_AT_OR_ABOVE;
        track_request = 1'b1;
      end
    end
  endfunction

  task automatic set_reg(input cfg_reg_t idx, input logic [FB-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RISE_LOAD:       ctl.rise_load       = val[PCT_W-1:0];
      REG_FALL_LOAD:       ctl.fall_load       = val[PCT_W-1:0];
      REG_STEP_PERCENT:    ctl.step_percent    = val[PCT_W-1:0];
      REG_BOOST_ENABLE:    ctl.boost_enable    = val[0];
      REG_BOOST_THRESHOLD: ctl.boost_threshold = val[BOOST_W-1:0];
      REG_MAX_FREQ:        max_khz             = val;
      REG_MIN_FREQ:        min_khz             = val;
      REG_GOVERNOR_ON:     ctl.governor_on     = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input int up, input int down, input int stp, input int ben,
                           input int bthr, input int maxf, input int minf, input int gov);
    set_reg(REG_RISE_LOAD, FB'(up));
    set_reg(REG_FALL_LOAD, FB'(down));
    set_reg(REG_STEP_PERCENT, FB'(stp));
    set_reg(REG_BOOST_ENABLE, FB'(ben));
    set_reg(REG_BOOST_THRESHOLD, FB'(bthr));
    set_reg(REG_MAX_FREQ, FB'(maxf));
    set_reg(REG_MIN_FREQ, FB'(minf));
    set_reg(REG_GOVERNOR_ON, FB'(gov));
  endtask

  task automatic add_item(input logic act, input int load, input int cur, input logic susp,
                          input int newf);
    sample_t s;
    s.action       = act;
    s.load_percent = PCT_W'(load);
    s.current_freq = FB'(cur);
    s.suspended    = susp;
    s.new_freq     = FB'(newf);
    queued_samples.push_back(s);
    issued_count++;
  endtask

  task automatic add_random_items(input int n);
    int pick;
    int load;
    int cur;
    int newf;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 9 && ctl.rise_load < 100) load = $urandom_range(ctl.rise_load + 1, 100);
      else if (pick < 16 && ctl.fall_load > 0)
        load = $urandom_range(0, (ctl.fall_load > 100) ? 100 : ctl.fall_load - 1);
      else load = $urandom_range(0, 100);
      cur = ($urandom_range(0, 3) == 0) ? min_khz : $urandom_range(0, FREQ_TOP);
      if (min_khz <= max_khz && $urandom_range(0, 1)) newf = $urandom_range(min_khz, max_khz);
      else newf = $urandom_range(0, FREQ_TOP);
      add_item(($urandom_range(0, 7) == 0) ? ACTION_NOTICE : ACTION_LOAD, load, cur,
               $urandom_range(0, 9) == 0, newf);
    end
  endtask

  // hold off until every transaction has gone through and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    while (accepted_count != issued_count || owed_requests.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    logic    nxt_valid;
    sample_t s;
    nxt_valid = item_ch.valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (item_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_samples.size() > 0) begin
          s = queued_samples.pop_front();
          item_ch.action       <= s.action;
          item_ch.load_percent <= s.load_percent;
          item_ch.current_freq <= s.current_freq;
          item_ch.suspended    <= s.suspended;
          item_ch.new_freq     <= s.new_freq;
          nxt_valid = 1'b1;
          send_gap = draw_wait(send_calm);
        end
      end
    end
    item_ch.valid <= nxt_valid;
  end

  // request receiver with random stalls
  always @(negedge clk) begin
    if (result_taken) recv_gap = draw_wait(recv_calm);
    if (recv_gap > 0) begin
      recv_gap--;
      req_ch.ready <= 1'b0;
    end else begin
      req_ch.ready <= 1'b1;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    request_t want;
    sample_t  seen;
    item_taken   = !rst && item_ch.valid && item_ch.ready;
    result_taken = !rst && req_ch.valid && req_ch.ready;
    if (result_taken) begin
      if (owed_requests.size() == 0) begin
        $error("unexpected request target_freq=%0d relation=%0d",
               req_ch.target_freq, req_ch.relation);
        error_count++;
      end else begin
        want = owed_requests.pop_front();
        if (req_ch.target_freq !== want.target_freq) begin
          $error("target_freq: expected %0d, actual %0d", want.target_freq, req_ch.target_freq);
          error_count++;
        end
        if (req_ch.relation !== want.relation) begin
          $error("relation: expected %0d, actual %0d", want.relation, req_ch.relation);
          error_count++;
        end
      end
    end
    if (item_taken) begin
      seen.action       = item_ch.action;
      seen.load_percent = item_ch.load_percent;
      seen.current_freq = item_ch.current_freq;
      seen.suspended    = item_ch.suspended;
      seen.new_freq     = item_ch.new_freq;
      accepted_count++;
      if (track_request(seen, want)) owed_requests.push_back(want);
    end
    if (rst || item_taken || result_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int mx;
    int mn;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.action = ACTION_LOAD;
    item_ch.load_percent = '0;
    item_ch.current_freq = '0;
    item_ch.suspended = 1'b0;
    item_ch.new_freq = '0;
    req_ch.ready = 1'b0;
    ctl.rise_load = RISE_LOAD_RST;
    ctl.fall_load = FALL_LOAD_RST;
    ctl.step_percent = STEP_PERCENT_RST;
    ctl.boost_enable = BOOST_ENABLE_RST;
    ctl.boost_threshold = BOOST_THRESHOLD_RST;
    ctl.governor_on = GOVERNOR_ON_RST;
    max_khz = MAX_FREQ_RST[FB-1:0];
    min_khz = MIN_FREQ_RST[FB-1:0];
    req_khz = '0;
    rise_cnt = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset settings: seed by notice, plain rises, boost, edges of thresholds
    add_item(ACTION_NOTICE, 0, 0, 1'b0, 1000000);
    add_item(ACTION_LOAD, 100, 1000000, 1'b0, 0);
    add_item(ACTION_LOAD, 100, 1000000, 1'b1, 0);
    add_item(ACTION_LOAD, 81, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 90, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 100, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 100, FREQ_TOP, 1'b0, FREQ_TOP);
    add_item(ACTION_LOAD, 80, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 0, 300000, 1'b0, 0);
    add_item(ACTION_LOAD, 19, FREQ_TOP, 1'b0, 0);
    add_item(ACTION_LOAD, 20, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 50, 0, 1'b0, 0);
    add_item(ACTION_NOTICE, 0, 0, 1'b0, 5);
    add_item(ACTION_LOAD, 0, 0, 1'b1, 0);
    settle();

    // thresholds in odd order, full-scale step
    configure(0, 100, 100, 0, 0, FREQ_TOP, 0, 1);
    add_item(ACTION_LOAD, 0, 5, 1'b0, 0);
    add_item(ACTION_LOAD, 1, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 100, FREQ_TOP, 1'b0, 0);
    add_item(ACTION_NOTICE, 100, 0, 1'b1, 0);
    settle();

    // tiny range: step falls back, boost right away, requested above max
    configure(50, 11, 1, 1, 0, 50, 10, 1);
    add_item(ACTION_LOAD, 51, 0, 1'b0, 0);
    add_item(ACTION_NOTICE, 0, 0, 1'b0, 20);
    add_item(ACTION_LOAD, 51, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 10, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 10, 0, 1'b0, 0);
    settle();

    // minimum above maximum
    configure(80, 20, 5, 1, 3, 1000, FREQ_TOP, 1);
    add_item(ACTION_NOTICE, 0, 0, 1'b0, 777);
    add_item(ACTION_LOAD, 100, 0, 1'b0, 0);
    add_item(ACTION_LOAD, 0, 1, 1'b0, 0);
    settle();

    configure(80, 20, 5, 1, 3, 2000000, 300000, 1);
    add_random_items(120);
    settle();
    configure(0, 100, 100, 0, 0, FREQ_TOP, 0, 1);
    add_random_items(100);
    settle();
    configure(80, 20, 0, 1, 3, 2000000, 300000, 1);
    add_random_items(40);
    settle();
    configure(50, 11, 1, 1, 0, 50, 10, 1);
    add_random_items(100);
    settle();
    configure(60, 30, 1, 0, 5, FREQ_TOP, 100000, 1);
    add_random_items(120);
    settle();
    configure(70, 40, 7, 1, 5, 3000000, 100000, 0);
    add_random_items(100);
    settle();
    configure(100, 11, 50, 1, 2, 0, 0, 1);
    add_random_items(60);
    settle();
    configure(40, 60, 10, 1, 1, 1000, FREQ_TOP, 1);
    add_random_items(80);
    settle();

    repeat (6) begin
      mx = $urandom_range(0, FREQ_TOP);
      mn = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FREQ_TOP) : $urandom_range(0, mx);
      configure($urandom_range(0, 100), $urandom_range(11, 100), $urandom_range(0, 100),
                $urandom_range(0, 1), $urandom_range(0, 5), mx, mn,
                ($urandom_range(0, 3) != 0) ? 1 : 0);
      add_random_items(80);
      settle();
    end

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: load_driven_frequency_stepper_unit.f
hdl/lfs_pkg.sv
hdl/lfs_channels.sv
hdl/lfs_cfg_regs.sv
hdl/load_driven_frequency_stepper_unit.sv
test/load_driven_frequency_stepper_unit_test.sv
